[hw/rtl/cpcr_pkg.sv]
package cpcr_pkg;

    localparam int MAIN_REG_COUNT = 8;
    localparam int PC_REG_COUNT   = 2;
    localparam int MAIN_IDX_W     = $clog2(MAIN_REG_COUNT);
    localparam int PC_IDX_W       = $clog2(PC_REG_COUNT);

    localparam int LOCAL_W  = 13;
    localparam int DRAM_W   = 24;
    localparam int STATUS_W = 15;
    localparam int ROWS_W   = 9;
    localparam int SKIP_W   = 12;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [MAIN_IDX_W-1:0] REG_MEM_ADDR  = 3'd0;
    localparam logic [MAIN_IDX_W-1:0] REG_DRAM_ADDR = 3'd1;
    localparam logic [MAIN_IDX_W-1:0] REG_RD_LEN    = 3'd2;
    localparam logic [MAIN_IDX_W-1:0] REG_WR_LEN    = 3'd3;
    localparam logic [MAIN_IDX_W-1:0] REG_STATUS    = 3'd4;
    localparam logic [MAIN_IDX_W-1:0] REG_DMA_FULL  = 3'd5;
    localparam logic [MAIN_IDX_W-1:0] REG_DMA_BUSY  = 3'd6;
    localparam logic [MAIN_IDX_W-1:0] REG_SEMAPHORE = 3'd7;

    localparam logic [STATUS_W-1:0] STATUS_RESET = 15'h0001;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        reg_space;
        logic [15:0] byte_offset;
        logic [31:0] write_data;
        logic [31:0] write_mask;
    } req_t;

    typedef struct packed {
        logic [31:0]        read_data;
        logic               access_error;
        logic               intr_clear_pulse;
        logic               intr_set_pulse;
        logic               task_start_pulse;
        logic               dma_valid;
        logic               dma_to_local;
        logic [LOCAL_W-1:0] local_addr;
        logic [DRAM_W-1:0]  dram_addr;
        logic               dma_last;
        logic               dma_busy;
    } rsp_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        access_error;
        logic        intr_clear_pulse;
        logic        intr_set_pulse;
        logic        task_start_pulse;
    } regs_rsp_t;

    typedef struct packed {
        logic               start;
        logic               to_local;
        logic [31:0]        len;
        logic [LOCAL_W-1:0] local_ptr;
        logic [DRAM_W-1:0]  dram_ptr;
    } dma_cmd_t;

    typedef struct packed {
        logic               dma_valid;
        logic               dma_to_local;
        logic [LOCAL_W-1:0] local_addr;
        logic [DRAM_W-1:0]  dram_addr;
        logic               dma_last;
    } dma_out_t;

endpackage

[hw/rtl/coprocessor_control_regs_dma_core.sv]
// A request is taken into the s1 stage register; its result is registered when the stage advances.
// Throughput: one request per cycle unless rsp_stall blocks intake; all register and DMA updates finish in one stage.
// A held result does not block intake until the single staged request is also waiting.
// Reset (rst_n low, asynchronous): registers, semaphore and DMA clear, status reads halted.
// Both pipeline valids clear on reset; no clearing pass is needed.
module coprocessor_control_regs_dma_core
    import cpcr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic      s1_valid_reg;
    req_t      s1_req_reg;
    logic      rsp_valid_reg;
    rsp_t      rsp_reg;
    rsp_t      rsp_next;
    logic      advance;
    logic      fire;
    logic      known;

    regs_rsp_t regs_rsp;
    dma_cmd_t  dma_cmd;
    dma_out_t  dma_out;
    logic      dma_active;
    logic      dma_active_next;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign fire      = advance;
    assign known     = (s1_req_reg.req_type == REQ_READ)
                    || (s1_req_reg.req_type == REQ_WRITE)
                    || (s1_req_reg.req_type == REQ_TICK);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    cpcr_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .req        (s1_req_reg),
        .dma_active (dma_active),
        .regs_rsp   (regs_rsp),
        .dma_cmd    (dma_cmd)
    );

    cpcr_dma u_dma (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .tick        (s1_req_reg.req_type == REQ_TICK),
        .dma_cmd     (dma_cmd),
        .active      (dma_active),
        .active_next (dma_active_next),
        .dma_out     (dma_out)
    );

    always_comb
    begin
        rsp_next = '0;
        if (known)
        begin
            rsp_next.read_data        = regs_rsp.read_data;
            rsp_next.access_error     = regs_rsp.access_error;
            rsp_next.intr_clear_pulse = regs_rsp.intr_clear_pulse;
            rsp_next.intr_set_pulse   = regs_rsp.intr_set_pulse;
            rsp_next.task_start_pulse = regs_rsp.task_start_pulse;
            rsp_next.dma_valid        = dma_out.dma_valid;
            rsp_next.dma_to_local     = dma_out.dma_to_local;
            rsp_next.local_addr       = dma_out.local_addr;
            rsp_next.dram_addr        = dma_out.dram_addr;
            rsp_next.dma_last         = dma_out.dma_last;
            rsp_next.dma_busy         = dma_active_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            s1_req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.dma_last |-> !rsp_reg.dma_busy)
        else $error("last byte reported with DMA still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.dma_valid
            |-> (rsp_reg.read_data == '0) && !rsp_reg.access_error
                && !rsp_reg.task_start_pulse)
        else $error("DMA byte mixed with register access result");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.access_error
            |-> (rsp_reg.read_data == '0) && !rsp_reg.intr_set_pulse
                && !rsp_reg.intr_clear_pulse && !rsp_reg.task_start_pulse)
        else $error("missing register produced side effects");

endmodule

[hw/rtl/cpcr_regs.sv]
module cpcr_regs
    import cpcr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  req_t      req,
    input  logic      dma_active,
    output regs_rsp_t regs_rsp,
    output dma_cmd_t  dma_cmd
);

    logic [LOCAL_W-1:0]  mem_addr_reg, mem_addr_next;
    logic [DRAM_W-1:0]   dram_addr_reg, dram_addr_next;
    logic [31:0]         rd_len_reg, rd_len_next;
    logic [31:0]         wr_len_reg, wr_len_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                sema_reg, sema_next;
    logic [31:0]         pc_reg [PC_REG_COUNT];
    logic [31:0]         pc_next;
    logic                pc_we;

    logic                  is_read;
    logic                  is_write;
    logic                  hit;
    logic [MAIN_IDX_W-1:0] midx;
    logic [PC_IDX_W-1:0]   pidx;
    logic [31:0]           wv;
    logic [31:0]           pc_old;

    assign is_read  = (req.req_type == REQ_READ);
    assign is_write = (req.req_type == REQ_WRITE);
    assign midx     = req.byte_offset[MAIN_IDX_W+1:2];
    assign pidx     = req.byte_offset[PC_IDX_W+1:2];
    assign hit      = req.reg_space ? (req.byte_offset[15:PC_IDX_W+2] == '0)
                                    : (req.byte_offset[15:MAIN_IDX_W+2] == '0);
    assign wv       = req.write_data & req.write_mask;
    assign pc_old   = pc_reg[pidx];
    assign pc_next  = (pc_old & ~req.write_mask) | wv;

    always_comb
    begin
        mem_addr_next  = mem_addr_reg;
        dram_addr_next = dram_addr_reg;
        rd_len_next    = rd_len_reg;
        wr_len_next    = wr_len_reg;
        status_next    = status_reg;
        sema_next      = sema_reg;
        pc_we          = 1'b0;
        regs_rsp       = '0;
        dma_cmd        = '0;
        dma_cmd.local_ptr = mem_addr_reg;
        dma_cmd.dram_ptr  = dram_addr_reg;

        if ((is_read || is_write) && !hit)
        begin
            regs_rsp.access_error = 1'b1;
        end
        else if (is_read)
        begin
            if (req.reg_space)
            begin
                regs_rsp.read_data = pc_old;
            end
            else
            begin
                unique case (midx)
                    REG_MEM_ADDR:  regs_rsp.read_data = 32'(mem_addr_reg);
                    REG_DRAM_ADDR: regs_rsp.read_data = 32'(dram_addr_reg);
                    REG_RD_LEN:    regs_rsp.read_data = rd_len_reg;
                    REG_WR_LEN:    regs_rsp.read_data = wr_len_reg;
                    REG_STATUS:    regs_rsp.read_data = 32'(status_reg);
                    REG_DMA_FULL:  regs_rsp.read_data = '0;
                    REG_DMA_BUSY:  regs_rsp.read_data = 32'(dma_active);
                    REG_SEMAPHORE:
                    begin
                        regs_rsp.read_data = 32'(sema_reg);
                        sema_next          = 1'b1;
                    end
                    default:       regs_rsp.read_data = '0;
                endcase
            end
        end
        else if (is_write)
        begin
            if (req.reg_space)
            begin
                pc_we = 1'b1;
            end
            else
            begin
                unique case (midx)
                    REG_MEM_ADDR:
                        mem_addr_next = (mem_addr_reg & ~req.write_mask[LOCAL_W-1:0])
                                      | wv[LOCAL_W-1:0];
                    REG_DRAM_ADDR:
                        dram_addr_next = (dram_addr_reg & ~req.write_mask[DRAM_W-1:0])
                                       | wv[DRAM_W-1:0];
                    REG_RD_LEN:
                    begin
                        rd_len_next      = (rd_len_reg & ~req.write_mask) | wv;
                        dma_cmd.start    = 1'b1;
                        dma_cmd.to_local = 1'b1;
                        dma_cmd.len      = rd_len_next;
                    end
                    REG_WR_LEN:
                    begin
                        wr_len_next      = (wr_len_reg & ~req.write_mask) | wv;
                        dma_cmd.start    = 1'b1;
                        dma_cmd.to_local = 1'b0;
                        dma_cmd.len      = wr_len_next;
                    end
                    REG_STATUS:
                    begin
                        // set wins over clear
                        if (wv[0]) status_next[0] = 1'b0;
                        if (wv[1]) status_next[0] = 1'b1;
                        if (wv[2]) status_next[1] = 1'b0;
                        if (wv[5]) status_next[5] = 1'b0;
                        if (wv[6]) status_next[5] = 1'b1;
                        if (wv[7]) status_next[6] = 1'b0;
                        if (wv[8]) status_next[6] = 1'b1;
                        for (int k = 0; k < 8; k++)
                        begin
                            if (wv[9 + 2*k])  status_next[7 + k] = 1'b0;
                            if (wv[10 + 2*k]) status_next[7 + k] = 1'b1;
                        end
                        regs_rsp.intr_clear_pulse = wv[3];
                        regs_rsp.intr_set_pulse   = wv[4];
                        regs_rsp.task_start_pulse = (wv[0] || wv[2])
                                                  && (status_next[1:0] == 2'b00);
                    end
                    REG_DMA_FULL, REG_DMA_BUSY: ;
                    REG_SEMAPHORE: sema_next = 1'b0;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_addr_reg  <= '0;
            dram_addr_reg <= '0;
            rd_len_reg    <= '0;
            wr_len_reg    <= '0;
            status_reg    <= STATUS_RESET;
            sema_reg      <= 1'b0;
            for (int i = 0; i < PC_REG_COUNT; i++)
            begin
                pc_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            mem_addr_reg  <= mem_addr_next;
            dram_addr_reg <= dram_addr_next;
            rd_len_reg    <= rd_len_next;
            wr_len_reg    <= wr_len_next;
            status_reg    <= status_next;
            sema_reg      <= sema_next;
            if (pc_we)
            begin
                pc_reg[pidx] <= pc_next;
            end
        end
    end

    // broke is clear-only and bits 2..4 are unused
    assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[4:1] == 4'b0000)
        else $error("status reserved or broke bit set");

endmodule

[hw/rtl/cpcr_dma.sv]
module cpcr_dma
    import cpcr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  logic     tick,
    input  dma_cmd_t dma_cmd,
    output logic     active,
    output logic     active_next,
    output dma_out_t dma_out
);

    logic               active_reg;
    logic               dir_reg, dir_next;
    logic [LOCAL_W-1:0] local_ptr_reg, local_ptr_next;
    logic [DRAM_W-1:0]  dram_ptr_reg, dram_ptr_next;
    logic [LOCAL_W-1:0] bytes_left_reg, bytes_left_next;
    logic [ROWS_W-1:0]  rows_left_reg, rows_left_next;
    logic [LOCAL_W-1:0] row_len_reg, row_len_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next;

    logic [LOCAL_W-1:0] bytes_dec;
    logic [ROWS_W-1:0]  rows_dec;
    logic [DRAM_W-1:0]  dram_inc;
    logic [DRAM_W-1:0]  dram_skip;

    assign active    = active_reg;
    assign bytes_dec = bytes_left_reg - 1'b1;
    assign rows_dec  = rows_left_reg - 1'b1;
    assign dram_inc  = dram_ptr_reg + 1'b1;
    assign dram_skip = dram_ptr_reg + DRAM_W'(skip_reg) + 1'b1;

    always_comb
    begin
        active_next     = active_reg;
        dir_next        = dir_reg;
        local_ptr_next  = local_ptr_reg;
        dram_ptr_next   = dram_ptr_reg;
        bytes_left_next = bytes_left_reg;
        rows_left_next  = rows_left_reg;
        row_len_next    = row_len_reg;
        skip_next       = skip_reg;
        dma_out         = '0;

        if (dma_cmd.start)
        begin
            active_next     = 1'b1;
            dir_next        = dma_cmd.to_local;
            row_len_next    = {1'b0, dma_cmd.len[11:0] | 12'h007} + 1'b1;
            bytes_left_next = row_len_next;
            rows_left_next  = {1'b0, dma_cmd.len[19:12]} + 1'b1;
            skip_next       = dma_cmd.len[31:20];
            local_ptr_next  = dma_cmd.local_ptr;
            dram_ptr_next   = dma_cmd.dram_ptr;
        end
        else if (tick && active_reg)
        begin
            dma_out.dma_valid    = 1'b1;
            dma_out.dma_to_local = dir_reg;
            dma_out.local_addr   = local_ptr_reg;
            dma_out.dram_addr    = dram_ptr_reg;
            dma_out.dma_last     = (bytes_left_reg == LOCAL_W'(1))
                                && (rows_left_reg == ROWS_W'(1));

            // 12-bit offset wraps inside the bank
            local_ptr_next  = {local_ptr_reg[LOCAL_W-1], local_ptr_reg[LOCAL_W-2:0] + 1'b1};
            dram_ptr_next   = dram_inc;
            bytes_left_next = bytes_dec;
            if (bytes_dec == '0)
            begin
                rows_left_next = rows_dec;
                if (rows_dec == '0)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    bytes_left_next = row_len_reg;
                    dram_ptr_next   = dram_skip;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            dir_reg        <= 1'b0;
            local_ptr_reg  <= '0;
            dram_ptr_reg   <= '0;
            bytes_left_reg <= '0;
            rows_left_reg  <= '0;
            row_len_reg    <= '0;
            skip_reg       <= '0;
        end
        else if (fire)
        begin
            active_reg     <= active_next;
            dir_reg        <= dir_next;
            local_ptr_reg  <= local_ptr_next;
            dram_ptr_reg   <= dram_ptr_next;
            bytes_left_reg <= bytes_left_next;
            rows_left_reg  <= rows_left_next;
            row_len_reg    <= row_len_next;
            skip_reg       <= skip_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (bytes_left_reg != '0) && (rows_left_reg != '0))
        else $error("active transfer with empty counters");

    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (bytes_left_reg <= row_len_reg))
        else $error("row byte count exceeds row length");

endmodule
